@@ rtl/rahe_pkg.sv @@
// ----------------------------------------------------------------------------
// rahe_pkg: shared types and constants of the rotor angle Hall emulator
// Field widths, fixed-point angle constants, register indexes, the request
// and response structs of the serial scaler, and the sector/Hall lookups.
// ----------------------------------------------------------------------------
package rahe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ELAPSED_W  = 16;
  localparam int DT_W       = 14;
  localparam int PULSE_W    = 11;
  localparam int ANGLE_W    = 25;
  localparam int SPEED_W    = 32;
  localparam int ACCEL_W    = 33;
  localparam int SETPT_W    = 24;
  localparam int SECTOR_W   = 3;
  localparam int HALL_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  // serial scaler: round(mag * dt / 1e6)
  localparam int MAG_W      = 33;
  localparam int PROD_W     = MAG_W + DT_W;
  localparam int REM_W      = 20;
  localparam int REM_X_W    = REM_W + 1;
  localparam int QUOT_W     = 28;
  localparam int STEP_CNT_W = $clog2(PROD_W);

  // signed angle sum before wrapping
  localparam int SUM_W      = 30;

  localparam logic [DT_W-1:0]    MIN_UPDATE_US  = DT_W'(1000);
  localparam logic [DT_W-1:0]    MAX_ELAPSED_US = DT_W'(16383);
  localparam logic [PULSE_W-1:0] PULSE_WIDTH_US = PULSE_W'(1200);
  localparam int                 GATE_WIDTH_DEG = 6;

  localparam logic [REM_X_W-1:0] US_PER_S = REM_X_W'(1000000);
  localparam logic [REM_W-1:0]   US_HALF  = REM_W'(500000);

  localparam logic [ANGLE_W-1:0] DEG_60   = ANGLE_W'(60 << FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_180  = ANGLE_W'(180 << FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_360  = ANGLE_W'(360 << FRAC_BITS);
  localparam logic [ANGLE_W-1:0] DEG_GATE = ANGLE_W'(GATE_WIDTH_DEG << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_360 = SUM_W'(360 << FRAC_BITS);

  localparam logic [SPEED_W-1:0] TARGET_RST = SPEED_W'(30 << FRAC_BITS);
  localparam logic [ACCEL_W-1:0] ACCEL_RST  = ACCEL_W'(180 << FRAC_BITS);
  localparam logic [SETPT_W-1:0] SETPT_RST  = SETPT_W'(90 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_FAULT    = 3'd1,
    REG_TARGET   = 3'd2,
    REG_ACCEL    = 3'd3,
    REG_SETPOINT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag;
    logic [DT_W-1:0]   dt;
  } scale_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] result;
  } scale_rsp_t;

  function automatic logic [SECTOR_W-1:0] sector_of(input logic [ANGLE_W-1:0] ang);
    logic [SECTOR_W-1:0] s;
    priority if (ang >= ANGLE_W'(5 * (60 << FRAC_BITS))) s = 3'd5;
    else if (ang >= ANGLE_W'(4 * (60 << FRAC_BITS)))     s = 3'd4;
    else if (ang >= ANGLE_W'(3 * (60 << FRAC_BITS)))     s = 3'd3;
    else if (ang >= ANGLE_W'(2 * (60 << FRAC_BITS)))     s = 3'd2;
    else if (ang >= DEG_60)                              s = 3'd1;
    else                                                 s = 3'd0;
    return s;
  endfunction

  function automatic logic [HALL_W-1:0] hall_of(input logic [SECTOR_W-1:0] sec);
    logic [HALL_W-1:0] h;
    unique case (sec)
      3'd0:    h = 3'b001;
      3'd1:    h = 3'b101;
      3'd2:    h = 3'b100;
      3'd3:    h = 3'b110;
      3'd4:    h = 3'b010;
      3'd5:    h = 3'b011;
      default: h = 3'b000;
    endcase
    return h;
  endfunction

endpackage

@@ rtl/rahe_in_if.sv @@
// ----------------------------------------------------------------------------
// rahe_in_if: tick channel
// Valid/ready channel carrying the microseconds elapsed since the last tick.
// ----------------------------------------------------------------------------
interface rahe_in_if;
  logic                           valid;
  logic                           ready;
  logic [rahe_pkg::ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, output elapsed_us, input ready);
  modport sink   (input valid, input elapsed_us, output ready);
endinterface

@@ rtl/rahe_out_if.sv @@
// ----------------------------------------------------------------------------
// rahe_out_if: result channel
// Valid/ready channel carrying the emulated sensor state after each tick.
// ----------------------------------------------------------------------------
interface rahe_out_if;
  logic                                valid;
  logic                                ready;
  logic                                updated;
  logic [rahe_pkg::ANGLE_W-1:0]        angle;
  logic signed [rahe_pkg::SPEED_W-1:0] speed_now;
  logic [rahe_pkg::SECTOR_W-1:0]       sector;
  logic [rahe_pkg::HALL_W-1:0]         hall_code;
  logic                                zero_cross;
  logic                                index_mark;
  logic                                gate_open;
  logic                                fault_out;

  modport source (output valid, output updated, output angle, output speed_now,
                  output sector, output hall_code, output zero_cross,
                  output index_mark, output gate_open, output fault_out,
                  input ready);
  modport sink   (input valid, input updated, input angle, input speed_now,
                  input sector, input hall_code, input zero_cross,
                  input index_mark, input gate_open, input fault_out,
                  output ready);
endinterface

@@ rtl/rahe_scale.sv @@
// ----------------------------------------------------------------------------
// rahe_scale: bit-serial time scaler
// Computes round(mag * dt / 1e6), ties up, with a shift-add multiply over the
// bits of dt followed by a restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
module rahe_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rahe_pkg::scale_req_t req,
  output rahe_pkg::scale_rsp_t rsp
);

  typedef enum logic [3:0] {
    SC_IDLE = 4'b0001,
    SC_MUL  = 4'b0010,
    SC_DIV  = 4'b0100,
    SC_RND  = 4'b1000
  } sc_state_t;

  sc_state_t                          state_r, state_nxt;
  logic [rahe_pkg::STEP_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rahe_pkg::MAG_W-1:0]         mag_r, mag_nxt;
  logic [rahe_pkg::DT_W-1:0]          dt_r, dt_nxt;
  logic [rahe_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic [rahe_pkg::REM_W-1:0]         rem_r, rem_nxt;
  logic [rahe_pkg::QUOT_W-1:0]        quot_r, quot_nxt;
  logic [rahe_pkg::QUOT_W-1:0]        res_r, res_nxt;
  logic                               done_r, done_nxt;
  logic [rahe_pkg::REM_X_W-1:0]       trial;
  logic                               fits;

  assign trial = {rem_r, prod_r[rahe_pkg::PROD_W-1]};
  assign fits  = (trial >= rahe_pkg::US_PER_S);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    dt_nxt    = dt_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quot_nxt  = quot_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      SC_IDLE: begin
        if (req.start) begin
          mag_nxt   = req.mag;
          dt_nxt    = req.dt;
          prod_nxt  = '0;
          cnt_nxt   = rahe_pkg::STEP_CNT_W'(rahe_pkg::DT_W - 1);
          state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        // msb first: shift the partial product and add mag when the dt bit is set
        prod_nxt = {prod_r[rahe_pkg::PROD_W-2:0], 1'b0}
                 + (dt_r[rahe_pkg::DT_W-1] ? rahe_pkg::PROD_W'(mag_r) : '0);
        dt_nxt   = {dt_r[rahe_pkg::DT_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          cnt_nxt   = rahe_pkg::STEP_CNT_W'(rahe_pkg::PROD_W - 1);
          rem_nxt   = '0;
          quot_nxt  = '0;
          state_nxt = SC_DIV;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SC_DIV: begin
        rem_nxt  = fits ? rahe_pkg::REM_W'(trial - rahe_pkg::US_PER_S)
                        : trial[rahe_pkg::REM_W-1:0];
        quot_nxt = {quot_r[rahe_pkg::QUOT_W-2:0], fits};
        prod_nxt = {prod_r[rahe_pkg::PROD_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = SC_RND;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      SC_RND: begin
        // remainder at or above half a second rounds up
        res_nxt   = quot_r + rahe_pkg::QUOT_W'(rem_r >= rahe_pkg::US_HALF);
        done_nxt  = 1'b1;
        state_nxt = SC_IDLE;
      end
      default: state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    dt_r   <= dt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    res_r  <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == SC_IDLE)
    else $error("scaler started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == SC_DIV |=> rem_r < rahe_pkg::REM_W'(1000000))
    else $error("divide remainder out of range");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == SC_RND)
    else $error("done without a rounding step");

endmodule

@@ rtl/rotor_angle_hall_emulator.sv @@
// ----------------------------------------------------------------------------
// rotor_angle_hall_emulator: rotor angle and Hall sensor emulator
// Accumulates tick time, ramps speed, advances and wraps the rotor angle and
// derives sector, Hall code, zero-cross/index pulses and the gate window.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick transaction with elapsed_us; out_ch returns exactly one result
//   transaction per tick. cfg_we/cfg_index/cfg_wdata write the five registers (enable,
//   fault_flag, target_speed, accel_rate, angle_setpoint); the user must write them only
//   while no tick is in flight, which the block does not enforce; unknown indexes are ignored.
// Timing:
//   One tick at a time. A tick that does not run a simulation step goes from
//   acceptance straight to the finishing state. A tick that runs a step uses
//   the shared bit-serial scaler twice (speed change, then angle change), each
//   pass a multiply over the bits of dt, a divide and a rounding step, and
//   the angle wrap then folds the sum into one turn. When the work ends the
//   result is loaded into the output register that drives out_ch.
// Reset and stalls:
//   rst_n clears the rotor state and reloads the register defaults; the
//   first tick after reset only starts timing. The result sits in an output
//   register; while out_ch is stalled the block finishes the next tick's work
//   and then waits for that register to drain.
// ----------------------------------------------------------------------------
module rotor_angle_hall_emulator (
  input  logic                            clk,
  input  logic                            rst_n,
  rahe_in_if.sink                         in_ch,
  rahe_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rahe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rahe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_ACC_WAIT = 8'b0000_0010,
    ST_RAMP     = 8'b0000_0100,
    ST_SPD_GO   = 8'b0000_1000,
    ST_SPD_WAIT = 8'b0001_0000,
    ST_ADVANCE  = 8'b0010_0000,
    ST_WRAP     = 8'b0100_0000,
    ST_FINISH   = 8'b1000_0000
  } state_t;

  localparam int RAMP_W = rahe_pkg::SPEED_W + 2;

  state_t                                state_r, state_nxt;
  logic                                  enable_r, enable_nxt;
  logic                                  fault_r, fault_nxt;
  logic signed [rahe_pkg::SPEED_W-1:0]   target_r, target_nxt;
  logic [rahe_pkg::ACCEL_W-1:0]          accel_r, accel_nxt;
  logic [rahe_pkg::SETPT_W-1:0]          setpt_r, setpt_nxt;

  logic                                  started_r, started_nxt;
  logic [rahe_pkg::DT_W-1:0]             since_r, since_nxt;
  logic [rahe_pkg::DT_W-1:0]             dt_r, dt_nxt;
  logic [rahe_pkg::ANGLE_W-1:0]          angle_r, angle_nxt;
  logic [rahe_pkg::ANGLE_W-1:0]          prev_r, prev_nxt;
  logic signed [rahe_pkg::SPEED_W-1:0]   speed_r, speed_nxt;
  logic signed [rahe_pkg::SUM_W-1:0]     sum_r, sum_nxt;
  logic [rahe_pkg::PULSE_W-1:0]          zc_r, zc_nxt;
  logic [rahe_pkg::PULSE_W-1:0]          idx_r, idx_nxt;
  logic                                  gate_r, gate_nxt;
  logic                                  step_r, step_nxt;

  logic                                  out_valid_r, out_valid_nxt;
  logic                                  o_updated_r;
  logic [rahe_pkg::ANGLE_W-1:0]          o_angle_r;
  logic signed [rahe_pkg::SPEED_W-1:0]   o_speed_r;
  logic [rahe_pkg::SECTOR_W-1:0]         o_sector_r;
  logic [rahe_pkg::HALL_W-1:0]           o_hall_r;
  logic                                  o_zc_r;
  logic                                  o_idx_r;
  logic                                  o_gate_r;
  logic                                  o_fault_r;
  logic                                  out_load;

  rahe_pkg::scale_req_t                  req;
  rahe_pkg::scale_rsp_t                  rsp;

  // tick bookkeeping
  logic                                  in_acc;
  logic [rahe_pkg::DT_W+2:0]             acc_sum;
  logic [rahe_pkg::DT_W-1:0]             acc_sat;
  logic                                  run_step;
  logic [rahe_pkg::ELAPSED_W-1:0]        e_in;

  // speed ramp
  logic signed [rahe_pkg::SPEED_W-1:0]   desired;
  logic signed [RAMP_W-1:0]              spd_x, des_x, dlt_x, up_x, dn_x, ramp_x;
  logic [rahe_pkg::SPEED_W-1:0]          spd_mag;

  // angle advance and flags
  logic signed [rahe_pkg::SUM_W-1:0]     prev_x, adv_x;
  logic                                  crossed, wrapped, gate_calc;
  logic [rahe_pkg::ANGLE_W-1:0]          half, sp_lo, sp_hi;
  logic [rahe_pkg::PULSE_W-1:0]          zc_fin, idx_fin;
  logic                                  gate_fin;
  logic [rahe_pkg::SECTOR_W-1:0]         sec_now;

  rahe_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign e_in        = in_ch.elapsed_us;
  assign acc_sum     = (rahe_pkg::DT_W+3)'(since_r) + (rahe_pkg::DT_W+3)'(e_in);
  assign acc_sat     = (acc_sum > (rahe_pkg::DT_W+3)'(rahe_pkg::MAX_ELAPSED_US))
                       ? rahe_pkg::MAX_ELAPSED_US : acc_sum[rahe_pkg::DT_W-1:0];
  assign run_step    = started_r & (acc_sat >= rahe_pkg::MIN_UPDATE_US);

  assign desired = (enable_r & ~fault_r) ? target_r : '0;
  assign spd_x   = RAMP_W'(speed_r);
  assign des_x   = RAMP_W'(desired);
  assign dlt_x   = $signed(RAMP_W'(rsp.result));
  assign up_x    = spd_x + dlt_x;
  assign dn_x    = spd_x - dlt_x;
  assign spd_mag = speed_r[rahe_pkg::SPEED_W-1] ? rahe_pkg::SPEED_W'(-speed_r)
                                                : rahe_pkg::SPEED_W'(speed_r);

  always_comb begin
    priority if (spd_x < des_x) ramp_x = (up_x < des_x) ? up_x : des_x;
    else if (spd_x > des_x)     ramp_x = (dn_x > des_x) ? dn_x : des_x;
    else                        ramp_x = spd_x;
  end

  assign prev_x = $signed(rahe_pkg::SUM_W'(angle_r));
  assign adv_x  = $signed(rahe_pkg::SUM_W'(rsp.result));

  assign crossed   = (prev_r < rahe_pkg::DEG_180) & (angle_r >= rahe_pkg::DEG_180);
  assign wrapped   = speed_r[rahe_pkg::SPEED_W-1] ? (angle_r > prev_r) : (angle_r < prev_r);
  assign half      = (angle_r >= rahe_pkg::DEG_180) ? angle_r - rahe_pkg::DEG_180 : angle_r;
  assign sp_lo     = rahe_pkg::ANGLE_W'(setpt_r);
  assign sp_hi     = sp_lo + rahe_pkg::DEG_GATE;
  assign gate_calc = enable_r & ~fault_r & (half >= sp_lo) & (half < sp_hi);

  assign zc_fin   = (step_r & (crossed | wrapped)) ? rahe_pkg::PULSE_WIDTH_US : zc_r;
  assign idx_fin  = (step_r & wrapped) ? rahe_pkg::PULSE_WIDTH_US : idx_r;
  assign gate_fin = step_r ? gate_calc : gate_r;
  assign sec_now  = rahe_pkg::sector_of(angle_r);

  assign out_load = (state_r == ST_FINISH) & (~out_valid_r | out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    fault_nxt     = fault_r;
    target_nxt    = target_r;
    accel_nxt     = accel_r;
    setpt_nxt     = setpt_r;
    started_nxt   = started_r;
    since_nxt     = since_r;
    dt_nxt        = dt_r;
    angle_nxt     = angle_r;
    prev_nxt      = prev_r;
    speed_nxt     = speed_r;
    sum_nxt       = sum_r;
    zc_nxt        = zc_r;
    idx_nxt       = idx_r;
    gate_nxt      = gate_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    req.start     = 1'b0;
    req.mag       = accel_r;
    req.dt        = acc_sat;

    if (cfg_we) begin
      unique case (cfg_index)
        rahe_pkg::REG_ENABLE:   enable_nxt = cfg_wdata[0];
        rahe_pkg::REG_FAULT:    fault_nxt  = cfg_wdata[0];
        rahe_pkg::REG_TARGET:   target_nxt = $signed(cfg_wdata[rahe_pkg::SPEED_W-1:0]);
        rahe_pkg::REG_ACCEL:    accel_nxt  = cfg_wdata[rahe_pkg::ACCEL_W-1:0];
        rahe_pkg::REG_SETPOINT: setpt_nxt  = cfg_wdata[rahe_pkg::SETPT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // pulse stretchers count down by the tick time on every transaction
          zc_nxt  = ((rahe_pkg::ELAPSED_W)'(zc_r) > e_in)
                    ? zc_r - e_in[rahe_pkg::PULSE_W-1:0] : '0;
          idx_nxt = ((rahe_pkg::ELAPSED_W)'(idx_r) > e_in)
                    ? idx_r - e_in[rahe_pkg::PULSE_W-1:0] : '0;
          if (!started_r) begin
            started_nxt = 1'b1;
            step_nxt    = 1'b0;
            state_nxt   = ST_FINISH;
          end else if (run_step) begin
            since_nxt = '0;
            dt_nxt    = acc_sat;
            step_nxt  = 1'b1;
            req.start = 1'b1;
            state_nxt = ST_ACC_WAIT;
          end else begin
            since_nxt = acc_sat;
            step_nxt  = 1'b0;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_ACC_WAIT: begin
        if (rsp.done) state_nxt = ST_RAMP;
      end
      ST_RAMP: begin
        speed_nxt = rahe_pkg::SPEED_W'(ramp_x);
        state_nxt = ST_SPD_GO;
      end
      ST_SPD_GO: begin
        req.start = 1'b1;
        req.mag   = rahe_pkg::MAG_W'(spd_mag);
        req.dt    = dt_r;
        state_nxt = ST_SPD_WAIT;
      end
      ST_SPD_WAIT: begin
        if (rsp.done) state_nxt = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        prev_nxt  = angle_r;
        sum_nxt   = speed_r[rahe_pkg::SPEED_W-1] ? prev_x - adv_x : prev_x + adv_x;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        // fold into one turn, one 360 degree correction per cycle
        priority if (sum_r >= rahe_pkg::SUM_360) begin
          sum_nxt = sum_r - rahe_pkg::SUM_360;
        end else if (sum_r < 0) begin
          sum_nxt = sum_r + rahe_pkg::SUM_360;
        end else begin
          angle_nxt = sum_r[rahe_pkg::ANGLE_W-1:0];
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          zc_nxt        = zc_fin;
          idx_nxt       = idx_fin;
          gate_nxt      = gate_fin;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      fault_r     <= 1'b0;
      target_r    <= $signed(rahe_pkg::TARGET_RST);
      accel_r     <= rahe_pkg::ACCEL_RST;
      setpt_r     <= rahe_pkg::SETPT_RST;
      started_r   <= 1'b0;
      since_r     <= '0;
      angle_r     <= '0;
      speed_r     <= '0;
      zc_r        <= '0;
      idx_r       <= '0;
      gate_r      <= 1'b0;
      step_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      fault_r     <= fault_nxt;
      target_r    <= target_nxt;
      accel_r     <= accel_nxt;
      setpt_r     <= setpt_nxt;
      started_r   <= started_nxt;
      since_r     <= since_nxt;
      angle_r     <= angle_nxt;
      speed_r     <= speed_nxt;
      zc_r        <= zc_nxt;
      idx_r       <= idx_nxt;
      gate_r      <= gate_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r   <= dt_nxt;
    prev_r <= prev_nxt;
    sum_r  <= sum_nxt;
    if (out_load) begin
      o_updated_r <= step_r;
      o_angle_r   <= angle_r;
      o_speed_r   <= speed_r;
      o_sector_r  <= sec_now;
      o_hall_r    <= rahe_pkg::hall_of(sec_now);
      o_zc_r      <= (zc_fin != '0);
      o_idx_r     <= (idx_fin != '0);
      o_gate_r    <= gate_fin;
      o_fault_r   <= fault_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.updated    = o_updated_r;
  assign out_ch.angle      = o_angle_r;
  assign out_ch.speed_now  = o_speed_r;
  assign out_ch.sector     = o_sector_r;
  assign out_ch.hall_code  = o_hall_r;
  assign out_ch.zero_cross = o_zc_r;
  assign out_ch.index_mark = o_idx_r;
  assign out_ch.gate_open  = o_gate_r;
  assign out_ch.fault_out  = o_fault_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r < rahe_pkg::DEG_360)
    else $error("rotor angle left one turn");

  a_since_range: assert property (@(posedge clk) disable iff (!rst_n)
    since_r < rahe_pkg::MIN_UPDATE_US)
    else $error("time accumulator kept a full update period");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == ST_ACC_WAIT || state_r == ST_SPD_WAIT))
    else $error("scaler finished while nobody waited");

  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");

  a_step_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC_WAIT) |-> (started_r && step_r))
    else $error("step running before timing started");

endmodule
